FILE: hw/rtl/dnarh_pkg.sv
// Shared types and constants for the DNA rolling window hash block.
`timescale 1ns / 1ps
`default_nettype none

package dnarh_pkg;

    localparam int DEF_HASH_WIDTH = 32;
    localparam int CNT_W          = 7;
    localparam int IDX_W          = 2;
    localparam int SYM_W          = 2;

    localparam logic [IDX_W-1:0] REG_MODULUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_WLEN    = 2'd1;
    localparam logic [IDX_W-1:0] REG_POW     = 2'd2;

    localparam logic [CNT_W-1:0] WLEN_RESET = 7'd1;
    localparam longint MOD_RESET = 64'd1000000007;

    // Datapath micro-operations.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD_H,
        OP_RED,
        OP_LOAD_P,
        OP_DBL,
        OP_DBL_D1,
        OP_ADD_D1,
        OP_SAVE_D3,
        OP_S1,
        OP_S2,
        OP_S3,
        OP_CLEAR
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NLOADH,
        ST_NREDH,
        ST_NLOADP,
        ST_NREDP,
        ST_NDBL1,
        ST_NDBL2,
        ST_ND2,
        ST_ND3,
        ST_NSAVE,
        ST_CLEAR,
        ST_S1,
        ST_S2,
        ST_S3
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   capture;
        logic   commit;
    } dp_cmd_t;

    typedef struct packed {
        logic was_full;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dnarh_modunit.sv
// Modular add/subtract unit: one addition and one conditional correction by q.
`timescale 1ns / 1ps
`default_nettype none

module dnarh_modunit #(
    parameter int HASH_WIDTH = dnarh_pkg::DEF_HASH_WIDTH
) (
    input  wire logic [HASH_WIDTH-1:0] q,
    input  wire logic [HASH_WIDTH-1:0] x,
    input  wire logic [HASH_WIDTH-1:0] y,
    input  wire logic                  cin,
    input  wire logic                  sub,
    output logic      [HASH_WIDTH-1:0] r
);

    logic [HASH_WIDTH:0] sum;
    logic [HASH_WIDTH:0] q_ext;
    logic [HASH_WIDTH:0] fix;

    assign q_ext = {1'b0, q};

    // x, y < q: add gives < 2q, subtract borrows at most once.
    always_comb
    begin
        if (sub)
        begin
            sum = {1'b0, x} - {1'b0, y};
            fix = sum[HASH_WIDTH] ? (sum + q_ext) : sum;
        end
        else
        begin
            sum = {1'b0, x} + {1'b0, y} + {{HASH_WIDTH{1'b0}}, cin};
            fix = (sum >= q_ext) ? (sum - q_ext) : sum;
        end
        r = fix[HASH_WIDTH-1:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dnarh_dp.sv
// Datapath: config registers, hash state, reduction registers and result register.
`timescale 1ns / 1ps
`default_nettype none

module dnarh_dp #(
    parameter int HASH_WIDTH = dnarh_pkg::DEF_HASH_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dnarh_pkg::dp_cmd_t           cmd,
    output dnarh_pkg::dp_status_t             status,
    input  wire logic                         cfg_we,
    input  wire logic [dnarh_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [HASH_WIDTH-1:0]        cfg_data,
    input  wire logic [dnarh_pkg::SYM_W-1:0]  in_symbol,
    input  wire logic [dnarh_pkg::SYM_W-1:0]  out_symbol,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic      [HASH_WIDTH-1:0]        out_hash,
    output logic                              out_full
);

    import dnarh_pkg::*;

    logic [HASH_WIDTH-1:0] modulus_reg, modulus_next;
    logic [CNT_W-1:0]      wlen_reg, wlen_next;
    logic [HASH_WIDTH-1:0] pow_reg, pow_next;
    logic [HASH_WIDTH-1:0] hash_reg, hash_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  out_valid_reg, out_valid_next;

    logic [HASH_WIDTH-1:0] acc_reg, acc_next;
    logic [HASH_WIDTH-1:0] sh_reg, sh_next;
    logic [HASH_WIDTH-1:0] hred_reg, hred_next;
    logic [HASH_WIDTH-1:0] d1_reg, d1_next;
    logic [HASH_WIDTH-1:0] d2_reg, d2_next;
    logic [HASH_WIDTH-1:0] d3_reg, d3_next;
    logic [SYM_W-1:0]      sin_reg, sin_next;
    logic [SYM_W-1:0]      sout_reg, sout_next;
    logic                  was_full_reg, was_full_next;
    logic [HASH_WIDTH-1:0] out_hash_reg, out_hash_next;
    logic                  out_full_reg, out_full_next;

    logic [HASH_WIDTH-1:0] u_x, u_y, u_r, drop, res;
    logic                  u_cin, u_sub;
    logic [CNT_W-1:0]      cnt_upd;

    dnarh_modunit #(.HASH_WIDTH(HASH_WIDTH)) u_modunit (
        .q   (modulus_reg),
        .x   (u_x),
        .y   (u_y),
        .cin (u_cin),
        .sub (u_sub),
        .r   (u_r)
    );

    always_comb
    begin
        unique case (sout_reg)
            2'd0:    drop = '0;
            2'd1:    drop = d1_reg;
            2'd2:    drop = d2_reg;
            default: drop = d3_reg;
        endcase
    end

    // operand selection for the shared modular unit
    always_comb
    begin
        u_x   = acc_reg;
        u_y   = acc_reg;
        u_cin = 1'b0;
        u_sub = 1'b0;
        unique case (cmd.op)
            OP_RED:    u_cin = sh_reg[HASH_WIDTH-1];
            OP_ADD_D1: u_y = d1_reg;
            OP_S1:
            begin
                u_x   = hred_reg;
                u_y   = hred_reg;
                u_cin = sin_reg[1];
            end
            OP_S2:     u_cin = sin_reg[0];
            OP_S3:
            begin
                u_y   = drop;
                u_sub = 1'b1;
            end
            default:   u_cin = 1'b0;
        endcase
    end

    always_comb
    begin
        if (count_reg < wlen_reg)
            cnt_upd = count_reg + 1'b1;
        else
            cnt_upd = wlen_reg;
        res = ((cmd.op == OP_CLEAR) || (modulus_reg == '0)) ? '0 : u_r;
    end

    always_comb
    begin
        modulus_next   = modulus_reg;
        wlen_next      = wlen_reg;
        pow_next       = pow_reg;
        hash_next      = hash_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        acc_next       = acc_reg;
        sh_next        = sh_reg;
        hred_next      = hred_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        d3_next        = d3_reg;
        sin_next       = sin_reg;
        sout_next      = sout_reg;
        was_full_next  = was_full_reg;
        out_hash_next  = out_hash_reg;
        out_full_next  = out_full_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS: modulus_next = cfg_data;
                REG_WLEN:    wlen_next = cfg_data[CNT_W-1:0];
                REG_POW:     pow_next = cfg_data;
                default:     wlen_next = wlen_reg;
            endcase
        end

        if (cmd.capture)
        begin
            sin_next      = in_symbol;
            sout_next     = out_symbol;
            was_full_next = (count_reg >= wlen_reg);
        end

        unique case (cmd.op)
            OP_LOAD_H:
            begin
                acc_next = '0;
                sh_next  = hash_reg;
            end
            OP_RED:
            begin
                acc_next = u_r;
                sh_next  = {sh_reg[HASH_WIDTH-2:0], 1'b0};
            end
            OP_LOAD_P:
            begin
                hred_next = acc_reg;
                acc_next  = '0;
                sh_next   = pow_reg;
            end
            OP_DBL:     acc_next = u_r;
            OP_DBL_D1:
            begin
                d1_next  = acc_reg;
                acc_next = u_r;
            end
            OP_ADD_D1:
            begin
                d2_next  = acc_reg;
                acc_next = u_r;
            end
            OP_SAVE_D3: d3_next = acc_reg;
            OP_S1, OP_S2, OP_S3: acc_next = u_r;
            default:    acc_next = acc_reg;
        endcase

        if (out_ready)
            out_valid_next = 1'b0;

        if (cmd.commit)
        begin
            hash_next      = res;
            hred_next      = res;
            count_next     = (cmd.op == OP_CLEAR) ? '0 : cnt_upd;
            out_hash_next  = res;
            out_full_next  = ((cmd.op == OP_CLEAR) ? '0 : cnt_upd) >= wlen_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= HASH_WIDTH'(MOD_RESET);
            wlen_reg      <= WLEN_RESET;
            pow_reg       <= HASH_WIDTH'(1);
            hash_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            modulus_reg   <= modulus_next;
            wlen_reg      <= wlen_next;
            pow_reg       <= pow_next;
            hash_reg      <= hash_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sh_reg       <= sh_next;
        hred_reg     <= hred_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        d3_reg       <= d3_next;
        sin_reg      <= sin_next;
        sout_reg     <= sout_next;
        was_full_reg <= was_full_next;
        out_hash_reg <= out_hash_next;
        out_full_reg <= out_full_next;
    end

    assign status.was_full = was_full_reg;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_hash        = out_hash_reg;
    assign out_full        = out_full_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/dnarh_ctrl.sv
// Controller: sequences modulus reduction after reset and after modulus or power writes, and the item steps.
`timescale 1ns / 1ps
`default_nettype none

module dnarh_ctrl #(
    parameter int HASH_WIDTH = dnarh_pkg::DEF_HASH_WIDTH
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_mode,
    input  wire logic                   norm_req,
    input  wire dnarh_pkg::dp_status_t  status,
    output logic                        in_ready,
    output dnarh_pkg::dp_cmd_t          cmd
);

    import dnarh_pkg::*;

    localparam int BW = $clog2(HASH_WIDTH);

    ctrl_state_t     state_reg, state_next;
    logic [BW-1:0]   bit_cnt_reg, bit_cnt_next;
    logic            last_bit;

    assign last_bit = (bit_cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = in_mode ? ST_CLEAR : ST_S1;
            end
            ST_NLOADH:
            begin
                state_next   = ST_NREDH;
                bit_cnt_next = BW'(HASH_WIDTH - 1);
            end
            ST_NREDH:
            begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (last_bit)
                    state_next = ST_NLOADP;
            end
            ST_NLOADP:
            begin
                state_next   = ST_NREDP;
                bit_cnt_next = BW'(HASH_WIDTH - 1);
            end
            ST_NREDP:
            begin
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (last_bit)
                    state_next = ST_NDBL1;
            end
            ST_NDBL1: state_next = ST_NDBL2;
            ST_NDBL2: state_next = ST_ND2;
            ST_ND2:   state_next = ST_ND3;
            ST_ND3:   state_next = ST_NSAVE;
            ST_NSAVE: state_next = ST_IDLE;
            ST_CLEAR:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_S1:    state_next = ST_S2;
            ST_S2:
            begin
                if (status.was_full)
                    state_next = ST_S3;
                else if (status.out_free)
                    state_next = ST_IDLE;
            end
            ST_S3:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
        // new modulus or power term restarts the reduction
        if (norm_req)
            state_next = ST_NLOADH;
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.op      = OP_IDLE;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_NLOADH: cmd.op = OP_LOAD_H;
            ST_NREDH:  cmd.op = OP_RED;
            ST_NLOADP: cmd.op = OP_LOAD_P;
            ST_NREDP:  cmd.op = OP_RED;
            ST_NDBL1:  cmd.op = OP_DBL;
            ST_NDBL2:  cmd.op = OP_DBL;
            ST_ND2:    cmd.op = OP_DBL_D1;
            ST_ND3:    cmd.op = OP_ADD_D1;
            ST_NSAVE:  cmd.op = OP_SAVE_D3;
            ST_CLEAR:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_CLEAR;
                    cmd.commit = 1'b1;
                end
            end
            ST_S1:     cmd.op = OP_S1;
            ST_S2:
            begin
                if (status.was_full)
                    cmd.op = OP_S2;
                else if (status.out_free)
                begin
                    cmd.op     = OP_S2;
                    cmd.commit = 1'b1;
                end
            end
            ST_S3:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_S3;
                    cmd.commit = 1'b1;
                end
            end
            default:   cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_NLOADH;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/dna_rolling_window_hash.sv
// Top level of the DNA rolling window hash (base 4, configurable modulus).
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | tdata: in_symbol, out_symbol
//            |           |                               | tuser: mode
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | tdata: hash_value
//            |           |                               | tuser: window_full
//  cfg       | in        | cfg_valid / cfg_ready         | cfg_index, cfg_data
//
// After acceptance, a clear request commits from ST_CLEAR, and a shift from ST_S2 while the
// window fills or from ST_S3 once it is full; s_axis_tready returns in the cycle after the commit,
// so a new request is taken only once the previous one has committed. The shared modular
// add/subtract unit does one step per cycle. After reset, and after each write of modulus or
// pow_term, the block reduces hash and power term bit-serially, with s_axis_tready low.
// A finished result sits in the output register; the next request is taken meanwhile
// and its last step waits only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module dna_rolling_window_hash #(
    parameter int HASH_WIDTH = dnarh_pkg::DEF_HASH_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // in_symbol, out_symbol
    input  wire logic                              s_axis_tuser,  // mode
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [((HASH_WIDTH+7)/8)*8-1:0]        m_axis_tdata,  // hash_value
    output logic                                   m_axis_tuser,  // window_full
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dnarh_pkg::IDX_W-1:0]       cfg_index,
    input  wire logic [HASH_WIDTH-1:0]             cfg_data
);

    import dnarh_pkg::*;

    localparam int OUT_DW = ((HASH_WIDTH + 7) / 8) * 8;

    dp_cmd_t               cmd;
    dp_status_t            status;
    logic                  cfg_we;
    logic                  norm_req;
    logic [HASH_WIDTH-1:0] out_hash;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign norm_req  = cfg_we && ((cfg_index == REG_MODULUS) || (cfg_index == REG_POW));

    dnarh_ctrl #(.HASH_WIDTH(HASH_WIDTH)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_mode  (s_axis_tuser),
        .norm_req (norm_req),
        .status   (status),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    dnarh_dp #(.HASH_WIDTH(HASH_WIDTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_symbol  (s_axis_tdata[1:0]),
        .out_symbol (s_axis_tdata[3:2]),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_hash   (out_hash),
        .out_full   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_DW'(out_hash);

endmodule

`default_nettype wire
